### sv/mai_pkg.sv
`default_nettype none

package mai_pkg;

    // Interlock states, as reported on the mode output
    typedef enum logic [1:0] {
        MODE_STANDBY = 2'd0,
        MODE_IDENT   = 2'd1,
        MODE_RUNNING = 2'd2,
        MODE_RESET   = 2'd3
    } t_mode;

    // Configuration register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_CONST_PRESENCE = 2'd0,
        REG_STOP_FILTER    = 2'd1,
        REG_CARD_FILTER    = 2'd2,
        REG_UNUSED         = 2'd3
    } t_reg_idx;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned FILTER_W = 16;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DATA_W   = 32;

    localparam logic                CONST_PRESENCE_RST = 1'b1;
    localparam logic [FILTER_W-1:0] STOP_FILTER_RST    = 16'd100;
    localparam logic [FILTER_W-1:0] CARD_FILTER_RST    = 16'd3000;

endpackage

`default_nettype wire

### sv/machine_access_interlock.sv
`default_nettype none

// Channel   Direction  Handshake                   Payload
// -------   ---------  --------------------------  ------------------------------------------
// poll      in         i_in_valid / o_in_stall     i_now_ms, i_card_seated, i_stop_held,
//                                                  i_auth_ok
// result    out        o_out_valid / i_out_stall   o_mode_code, o_relay_on, o_led_red,
//                                                  o_led_yellow, o_led_green
// config    in         APB (psel/penable/pready)   paddr, pwdata, prdata
//
// One item per cycle sustained while the result is not stalled. An item is held in the input
// register and then moves, in a single step, through the state machine and both filter timers
// (one 32-bit wrapping subtract and compare each) into the result register, where it is valid
// and can be taken. Synchronous active-low reset returns standby, clears both timers and loads
// the register defaults. A stalled result holds the result register; the input register then
// fills and o_in_stall rises until the result is taken.
module machine_access_interlock (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_in_valid,
    output      logic                          o_in_stall,
    input  wire logic [mai_pkg::TIME_W-1:0]    i_now_ms,
    input  wire logic                          i_card_seated,
    input  wire logic                          i_stop_held,
    input  wire logic                          i_auth_ok,

    output      logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    output      logic [1:0]                    o_mode_code,
    output      logic                          o_relay_on,
    output      logic                          o_led_red,
    output      logic                          o_led_yellow,
    output      logic                          o_led_green,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mai_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [mai_pkg::DATA_W-1:0]    pwdata,
    output      logic [mai_pkg::DATA_W-1:0]    prdata,
    output      logic                          pready
);
    import mai_pkg::*;

    // Configuration
    logic                r_const_presence;
    logic [FILTER_W-1:0] r_stop_filter;
    logic [FILTER_W-1:0] r_card_filter;
    t_reg_idx            w_reg_idx;
    logic                w_cfg_write;

    // Input register
    logic                r_in_valid;
    logic [TIME_W-1:0]   r_now_ms;
    logic                r_card;
    logic                r_stop;
    logic                r_auth;

    // Interlock state
    t_mode               r_mode,        n_mode;
    logic                r_stop_timing, n_stop_timing;
    logic [TIME_W-1:0]   r_stop_start,  n_stop_start;
    logic                r_card_timing, n_card_timing;
    logic [TIME_W-1:0]   r_card_start,  n_card_start;

    // Result register
    logic                r_out_valid;
    t_mode               r_out_mode;

    logic                w_out_adv;
    logic                w_in_adv;
    logic                w_step;
    logic [TIME_W-1:0]   w_stop_elapsed;
    logic [TIME_W-1:0]   w_card_elapsed;

    // ---------------------------------------------------------------------
    // Configuration port: always ready, writes land on the access phase
    // ---------------------------------------------------------------------
    assign pready      = 1'b1;
    assign w_reg_idx   = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (w_reg_idx)
            REG_CONST_PRESENCE: prdata = {{(DATA_W-1){1'b0}}, r_const_presence};
            REG_STOP_FILTER:    prdata = {{(DATA_W-FILTER_W){1'b0}}, r_stop_filter};
            REG_CARD_FILTER:    prdata = {{(DATA_W-FILTER_W){1'b0}}, r_card_filter};
            REG_UNUSED:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_const_presence <= CONST_PRESENCE_RST;
            r_stop_filter    <= STOP_FILTER_RST;
            r_card_filter    <= CARD_FILTER_RST;
        end else if (w_cfg_write) begin
            unique case (w_reg_idx)
                REG_CONST_PRESENCE: r_const_presence <= pwdata[0];
                REG_STOP_FILTER:    r_stop_filter    <= pwdata[FILTER_W-1:0];
                REG_CARD_FILTER:    r_card_filter    <= pwdata[FILTER_W-1:0];
                REG_UNUSED:         ; // drop writes beyond the register list
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Flow control: the result register advances when empty or taken; the
    // input register refills whenever its item moves on or it is empty.
    // ---------------------------------------------------------------------
    assign w_out_adv  = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_adv;
    assign w_in_adv   = !r_in_valid || w_out_adv;
    assign o_in_stall = !w_in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Payload: no reset needed, qualified by r_in_valid
    always_ff @(posedge i_clk) begin
        if (w_in_adv && i_in_valid) begin
            r_now_ms <= i_now_ms;
            r_card   <= i_card_seated;
            r_stop   <= i_stop_held;
            r_auth   <= i_auth_ok;
        end
    end

    // ---------------------------------------------------------------------
    // State machine and filter timers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_STANDBY;
            r_stop_timing <= 1'b0;
            r_stop_start  <= '0;
            r_card_timing <= 1'b0;
            r_card_start  <= '0;
        end else if (w_step) begin
            r_mode        <= n_mode;
            r_stop_timing <= n_stop_timing;
            r_stop_start  <= n_stop_start;
            r_card_timing <= n_card_timing;
            r_card_start  <= n_card_start;
        end
    end

    always_comb begin
        n_mode        = r_mode;
        n_stop_timing = r_stop_timing;
        n_stop_start  = r_stop_start;
        n_card_timing = r_card_timing;
        n_card_start  = r_card_start;

        // A timer that is not yet running starts at this poll's timestamp
        if (!r_stop_timing) begin
            n_stop_start = r_now_ms;
        end
        if (!r_card_timing) begin
            n_card_start = r_now_ms;
        end
        // Wrapping elapsed time since each timer started
        w_stop_elapsed = r_now_ms - n_stop_start;
        w_card_elapsed = r_now_ms - n_card_start;

        unique case (r_mode)
            MODE_STANDBY: begin
                if (r_card) begin
                    n_mode = MODE_IDENT;
                end
            end
            MODE_IDENT: begin
                n_mode = r_auth ? MODE_RUNNING : MODE_RESET;
            end
            MODE_RUNNING: begin
                if (r_const_presence) begin
                    // Stop must stay pressed for the filter time
                    if (r_stop) begin
                        n_stop_timing = 1'b1;
                        if (w_stop_elapsed >= {{(TIME_W-FILTER_W){1'b0}}, r_stop_filter}) begin
                            n_mode = MODE_RESET;
                        end
                    end else begin
                        n_stop_timing = 1'b0;
                    end
                    // Dead-man: card may be absent only up to the filter time
                    if (!r_card) begin
                        n_card_timing = 1'b1;
                        if (w_card_elapsed >= {{(TIME_W-FILTER_W){1'b0}}, r_card_filter}) begin
                            n_mode = MODE_RESET;
                        end
                    end else begin
                        n_card_timing = 1'b0;
                    end
                end else if (r_stop) begin
                    n_mode = MODE_RESET;
                end
                // Hold timer starts untouched unless a timer actually started here
                if (!(r_const_presence && r_stop)) begin
                    n_stop_start = r_stop_start;
                end
                if (!(r_const_presence && !r_card)) begin
                    n_card_start = r_card_start;
                end
            end
            MODE_RESET: begin
                if (!r_card && !r_stop) begin
                    n_mode = MODE_STANDBY;
                end
            end
        endcase

        // Outside running the timers are left exactly as they were
        if (r_mode != MODE_RUNNING) begin
            n_stop_start = r_stop_start;
            n_card_start = r_card_start;
        end
    end

    // ---------------------------------------------------------------------
    // Result register: new state, drives decoded on the way out
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_mode <= n_mode;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mode_code  = r_out_mode;
    assign o_relay_on   = (r_out_mode == MODE_RUNNING);
    assign o_led_red    = (r_out_mode == MODE_RESET);
    assign o_led_yellow = (r_out_mode == MODE_STANDBY) || (r_out_mode == MODE_IDENT);
    assign o_led_green  = (r_out_mode == MODE_IDENT) || (r_out_mode == MODE_RUNNING);

endmodule

`default_nettype wire
